>>> rtl/packet_header_checksum_check_macros.svh
// Assertion macros shared by the checksum checker RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef PACKET_HEADER_CHECKSUM_CHECK_MACROS_SVH
`define PACKET_HEADER_CHECKSUM_CHECK_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define PHCC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("phcc same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define PHCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("phcc next-cycle check failed");

`endif

>>> rtl/phcc_pkg.sv
// Types, header layout constants and length helpers for the checksum checker.
// Depends on nothing; used by the channel interfaces and the top level.
package phcc_pkg;

    localparam int unsigned WORD_W  = 16;
    localparam int unsigned ADDR_W  = 32;
    localparam int unsigned INDEX_W = 13;

    typedef logic [WORD_W-1:0]  t_word;
    typedef logic [ADDR_W-1:0]  t_addr;
    typedef logic [INDEX_W-1:0] t_index;

    // Header word positions
    localparam t_index IDX_SRC_HI = t_index'(0);
    localparam t_index IDX_SRC_LO = t_index'(1);
    localparam t_index IDX_DST_HI = t_index'(2);
    localparam t_index IDX_DST_LO = t_index'(3);
    localparam t_index IDX_SEQ    = t_index'(4);
    localparam t_index IDX_CHKSUM = t_index'(5);
    localparam t_index IDX_SIZE   = t_index'(6);

    localparam logic [16:0] HEADER_BITS = 17'd112;
    localparam t_index MIN_WORDS = t_index'(7);
    localparam t_index MAX_WORDS = t_index'(2056);

    // Magnitude of a word read as signed 16-bit; the most negative value maps to itself.
    function automatic t_word magnitude16(input t_word w);
        magnitude16 = w[WORD_W-1] ? t_word'(-w) : w;
    endfunction

    // Packet length in words: n = 112 + size, n += n mod 16, ceil(n / 16).
    function automatic t_index words_for_size(input t_word mag);
        logic [16:0] n;
        logic [17:0] padded;
        n      = HEADER_BITS + {1'b0, mag};
        padded = {1'b0, n} + {14'd0, n[3:0]} + 18'd15;
        words_for_size = padded[INDEX_W+3:4];
    endfunction

endpackage

>>> rtl/phcc_word_if.sv
// Input channel of the checksum checker: one packet word per request.
// Depends on phcc_pkg for the word type.
interface phcc_word_if;
    phcc_pkg::t_word data_word;
    logic            valid;
    logic            ready;

    modport source (output valid, output data_word, input ready);
    modport sink   (input valid, input data_word, output ready);
endinterface

>>> rtl/phcc_result_if.sv
// Result channel of the checksum checker: header fields and checksum verdict.
// Depends on phcc_pkg for the field types.
interface phcc_result_if;
    phcc_pkg::t_addr source_addr;
    phcc_pkg::t_addr dest_addr;
    phcc_pkg::t_word seq_number;
    phcc_pkg::t_word data_bits;
    phcc_pkg::t_word computed_checksum;
    logic            checksum_ok;
    logic            valid;
    logic            ready;

    modport source (output valid, output source_addr, output dest_addr, output seq_number,
                    output data_bits, output computed_checksum, output checksum_ok,
                    input ready);
    modport sink   (input valid, input source_addr, input dest_addr, input seq_number,
                    input data_bits, input computed_checksum, input checksum_ok,
                    output ready);
endinterface

>>> rtl/packet_header_checksum_check.sv
// Packet header parser and ones' complement checksum checker, top level.
// Depends on phcc_pkg, phcc_word_if, phcc_result_if and the assertion macro header.
//
// Packet words enter one per request on i_word, at up to one word per cycle; the
// block parses the seven-word header, folds every word except the checksum word into a
// 16-bit ones' complement sum and, on the packet's last word, presents one result on
// o_result with the addresses, magnitudes of the sequence and size words, the
// complemented sum and a match flag. A word passes an input register and then the
// end-around-carry adder into the result register, so a result is presented from the
// clock edge at which its last word leaves the input register; the adder
// and the length calculation on the size word set the cycle time. A stalled result holds
// the word behind it in the input register, and input flow resumes in the cycle the
// result is taken.
`include "packet_header_checksum_check_macros.svh"

module packet_header_checksum_check (
    input  logic          i_clk,
    input  logic          i_rst_n,
    phcc_word_if.sink     i_word,
    phcc_result_if.source o_result
);
    import phcc_pkg::*;

    // Input register
    logic   r_in_valid;
    t_word  r_in_word;

    // Packet state
    t_index r_idx,    n_idx;
    t_index r_total,  n_total;
    t_word  r_sum,    n_sum;
    t_addr  r_src,    n_src;
    t_addr  r_dst,    n_dst;
    t_word  r_seq,    n_seq;
    t_word  r_rx_chk, n_rx_chk;
    t_word  r_size,   n_size;

    // Result register
    logic   r_out_valid;
    t_addr  r_out_src;
    t_addr  r_out_dst;
    t_word  r_out_seq;
    t_word  r_out_bits;
    t_word  r_out_chk;
    logic   r_out_ok;

    logic        advance;
    logic        last;
    t_word       addend;
    logic [16:0] raw_sum;
    t_word       chk;

    assign advance      = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_word.ready = !r_in_valid || advance;

    always_comb begin
        n_src    = r_src;
        n_dst    = r_dst;
        n_seq    = r_seq;
        n_rx_chk = r_rx_chk;
        n_size   = r_size;
        n_total  = r_total;

        addend  = (r_idx == IDX_CHKSUM) ? '0 : r_in_word;
        raw_sum = {1'b0, r_sum} + {1'b0, addend};
        n_sum   = raw_sum[15:0] + {15'd0, raw_sum[16]};

        unique case (r_idx)
            IDX_SRC_HI: n_src[31:16] = r_in_word;
            IDX_SRC_LO: n_src[15:0]  = r_in_word;
            IDX_DST_HI: n_dst[31:16] = r_in_word;
            IDX_DST_LO: n_dst[15:0]  = r_in_word;
            IDX_SEQ:    n_seq        = r_in_word;
            IDX_CHKSUM: n_rx_chk     = r_in_word;
            IDX_SIZE: begin
                n_size  = r_in_word;
                n_total = words_for_size(magnitude16(r_in_word));
            end
            default: ;
        endcase

        last = (r_idx >= IDX_SIZE) && ((r_idx + t_index'(1)) == n_total);
        chk  = ~n_sum;
        n_idx = last ? '0 : r_idx + t_index'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
            r_total     <= '0;
            r_sum       <= '0;
            r_src       <= '0;
            r_dst       <= '0;
            r_seq       <= '0;
            r_rx_chk    <= '0;
            r_size      <= '0;
        end else begin
            // Input register: load on accept, drain on advance
            if (i_word.valid && i_word.ready) begin
                r_in_valid <= 1'b1;
                r_in_word  <= i_word.data_word;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end

            if (advance && last) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end

            if (advance) begin
                r_src    <= n_src;
                r_dst    <= n_dst;
                r_seq    <= n_seq;
                r_rx_chk <= n_rx_chk;
                r_size   <= n_size;
                r_idx    <= n_idx;
                r_total  <= last ? '0 : n_total;
                r_sum    <= last ? '0 : n_sum;
                if (last) begin
                    r_out_src   <= n_src;
                    r_out_dst   <= n_dst;
                    r_out_seq   <= magnitude16(n_seq);
                    r_out_bits  <= magnitude16(n_size);
                    r_out_chk   <= chk;
                    r_out_ok    <= (chk == n_rx_chk);
                end
            end
        end
    end

    assign o_result.valid             = r_out_valid;
    assign o_result.source_addr       = r_out_src;
    assign o_result.dest_addr         = r_out_dst;
    assign o_result.seq_number        = r_out_seq;
    assign o_result.data_bits         = r_out_bits;
    assign o_result.computed_checksum = r_out_chk;
    assign o_result.checksum_ok       = r_out_ok;

    // Length unknown means still inside the header
    `PHCC_ASSERT_NOW(a_hdr_index, i_clk, i_rst_n, (r_total == '0), (r_idx <= IDX_SIZE))
    // Once known, length is in range and the index stays below it
    `PHCC_ASSERT_NOW(a_len_range, i_clk, i_rst_n, (r_total != '0),
        ((r_total >= MIN_WORDS) && (r_total <= MAX_WORDS) && (r_idx < r_total)))
    // Packet end restarts the index and the sum
    `PHCC_ASSERT_NEXT(a_restart, i_clk, i_rst_n, (advance && last),
        ((r_idx == '0) && (r_sum == '0) && (r_total == '0) && r_out_valid))
    // A presented result agrees with the checksum word it was judged against
    `PHCC_ASSERT_NOW(a_verdict, i_clk, i_rst_n, r_out_valid,
        (r_out_ok == (r_out_chk == r_rx_chk)))

endmodule

>>> tb/tb_packet_header_checksum_check.sv
`timescale 1ns / 1ps
// Self-checking testbench for packet_header_checksum_check: streams packets word by word,
// predicts each header result and checksum verdict, and compares them with the block.
// Depends on phcc_pkg, phcc_word_if and phcc_result_if.
module tb_packet_header_checksum_check;
    import phcc_pkg::*;

    localparam int unsigned STALL_LIMIT  = 4000;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned PHASE_WORDS  = 290;

    typedef struct packed {
        t_addr src;
        t_addr dst;
        t_word seq;
        t_word bits;
        t_word chk;
        logic  ok;
    } t_header_result;

    typedef struct packed {
        logic           known;
        t_header_result res;
    } t_typed_result;

    typedef struct packed {
        t_addr          src;
        t_addr          dst;
        t_word          seq;
        t_word          chk;
        t_word          size;
        t_word          fill;
        logic           fix_chk;
        logic           known;
        t_header_result want;
    } t_packet_row;

    logic i_clk;
    logic i_rst_n;

    phcc_word_if   word_ch ();
    phcc_result_if res_ch ();

    packet_header_checksum_check dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_word   (word_ch),
        .o_result (res_ch)
    );

    // words waiting to be offered, expected results, typed-in results per packet
    t_word          word_q[$];
    t_header_result expect_q[$];
    t_typed_result  typed_q[$];

    int unsigned send_gap_pct;
    int unsigned recv_stall_pct;
    int unsigned mismatches;
    int unsigned words_in;
    int unsigned packets_built;
    int unsigned results_checked;
    int unsigned good_sums;
    int unsigned idle_cycles;

    // checker state
    t_index pos;
    t_index pkt_len;
    t_word  sum_acc;
    t_addr  src_hold;
    t_addr  dst_hold;
    t_word  seq_hold;
    t_word  chk_hold;
    t_word  size_hold;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_word ones_add(input t_word a, input t_word b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

    function automatic t_word abs16(input t_word w);
        return w[15] ? t_word'(17'h10000 - {1'b0, w}) : w;
    endfunction

    function automatic int unsigned packet_words(input t_word size_word);
        int unsigned n;
        n = 112 + abs16(size_word);
        n = n + (n % 16);
        return (n + 15) / 16;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic field_check(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h want %h", name, got, want));
    endtask

    // Advance the checker by one accepted word; queue a result on the packet's last word.
    task automatic absorb_word(input t_word w);
        t_header_result res;
        t_typed_result  typed;
        t_index         idx;
        idx     = pos;
        sum_acc = ones_add(sum_acc, (idx == IDX_CHKSUM) ? t_word'(0) : w);
        case (idx)
            IDX_SRC_HI: src_hold[31:16] = w;
            IDX_SRC_LO: src_hold[15:0]  = w;
            IDX_DST_HI: dst_hold[31:16] = w;
            IDX_DST_LO: dst_hold[15:0]  = w;
            IDX_SEQ:    seq_hold        = w;
            IDX_CHKSUM: chk_hold        = w;
            IDX_SIZE: begin
                size_hold = w;
                pkt_len   = t_index'(packet_words(w));
            end
            default: ;
        endcase
        if (idx >= IDX_SIZE && idx + t_index'(1) == pkt_len) begin
            res.src  = src_hold;
            res.dst  = dst_hold;
            res.seq  = abs16(seq_hold);
            res.bits = abs16(size_hold);
            res.chk  = ~sum_acc;
            res.ok   = (res.chk == chk_hold);
            typed    = typed_q.pop_front();
            expect_q.push_back(typed.known ? typed.res : res);
            pos     = '0;
            pkt_len = '0;
            sum_acc = '0;
        end else begin
            pos = idx + t_index'(1);
        end
    endtask

    // Lay out one packet, optionally patch in a correct checksum, and queue its words.
    task automatic build_packet(input t_packet_row row, input logic rand_fill);
        t_word       pkt[$];
        t_word       s;
        int unsigned n;
        t_typed_result typed;
        n   = packet_words(row.size);
        pkt = {row.src[31:16], row.src[15:0], row.dst[31:16], row.dst[15:0],
               row.seq, row.chk, row.size};
        for (int unsigned i = 7; i < n; i++)
            pkt.push_back(rand_fill ? t_word'($urandom) : row.fill);
        if (row.fix_chk) begin
            s = '0;
            foreach (pkt[i])
                if (i != int'(IDX_CHKSUM))
                    s = ones_add(s, pkt[i]);
            pkt[IDX_CHKSUM] = ~s;
        end
        foreach (pkt[i])
            word_q.push_back(pkt[i]);
        typed.known = row.known;
        typed.res   = row.want;
        typed_q.push_back(typed);
        packets_built++;
    endtask

    function automatic t_packet_row random_row();
        t_packet_row row;
        int unsigned r;
        row         = '0;
        row.src     = $urandom;
        row.dst     = $urandom;
        row.seq     = t_word'($urandom);
        row.chk     = t_word'($urandom);
        row.fix_chk = 1'($urandom_range(1));
        r           = $urandom_range(99);
        // mostly short packets, both signs of the size word
        if (r < 55) begin
            row.size = t_word'($urandom_range(48));
        end else if (r < 85) begin
            row.size = t_word'(-$urandom_range(48, 1));
        end else begin
            row.size = t_word'($urandom_range(600));
            if ($urandom_range(1))
                row.size = -row.size;
        end
        return row;
    endfunction

    // Sender: offer the next request, hold it while not taken, feed the checker on acceptance.
    always @(posedge i_clk) begin
        logic took;
        if (!i_rst_n) begin
            word_ch.valid <= 1'b0;
        end else begin
            took = word_ch.valid && word_ch.ready;
            if (took) begin
                absorb_word(word_ch.data_word);
                words_in++;
            end
            if (word_ch.valid && !took) begin
                // hold the pending request
            end else if (word_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                word_ch.valid     <= 1'b1;
                word_ch.data_word <= word_q.pop_front();
            end else begin
                word_ch.valid <= 1'b0;
            end
        end
    end

    // Receiver: take results with random stalls and check each field.
    always @(posedge i_clk) begin
        t_header_result got;
        t_header_result want;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                got.src  = res_ch.source_addr;
                got.dst  = res_ch.dest_addr;
                got.seq  = res_ch.seq_number;
                got.bits = res_ch.data_bits;
                got.chk  = res_ch.computed_checksum;
                got.ok   = res_ch.checksum_ok;
                if (expect_q.size() == 0) begin
                    report_mismatch("result with no packet pending");
                end else begin
                    want = expect_q.pop_front();
                    field_check("source_addr", got.src, want.src);
                    field_check("dest_addr", got.dst, want.dst);
                    field_check("seq_number", 32'(got.seq), 32'(want.seq));
                    field_check("data_bits", 32'(got.bits), 32'(want.bits));
                    field_check("computed_checksum", 32'(got.chk), 32'(want.chk));
                    field_check("checksum_ok", 32'(got.ok), 32'(want.ok));
                    results_checked++;
                    if (want.ok)
                        good_sums++;
                end
            end
            res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: end the run when neither channel moves for too long.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((word_ch.valid && word_ch.ready) || (res_ch.valid && res_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("timeout: no request moved for %0d cycles", idle_cycles);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial begin
        t_packet_row directed_rows[3];
        t_packet_row row;
        int unsigned phase_words;

        i_rst_n           = 1'b0;
        word_ch.valid     = 1'b0;
        word_ch.data_word = '0;
        res_ch.ready      = 1'b0;
        send_gap_pct      = 0;
        recv_stall_pct    = 0;
        mismatches        = 0;
        words_in          = 0;
        packets_built     = 0;
        results_checked   = 0;
        good_sums         = 0;
        idle_cycles       = 0;
        pos               = '0;
        pkt_len           = '0;
        sum_acc           = '0;
        src_hold          = '0;
        dst_hold          = '0;
        seq_hold          = '0;
        chk_hold          = '0;
        size_hold         = '0;

        // smallest packet of zeros; all-ones packet; most negative sequence word with good sum
        directed_rows[0] = '{src: '0, dst: '0, seq: '0, chk: '0, size: '0, fill: '0,
                             fix_chk: 1'b0, known: 1'b1,
                             want: '{src: '0, dst: '0, seq: '0, bits: '0,
                                     chk: 16'hFFFF, ok: 1'b0}};
        directed_rows[1] = '{src: 32'hFFFF_FFFF, dst: 32'hFFFF_FFFF, seq: 16'hFFFF,
                             chk: 16'hFFFF, size: 16'hFFFF, fill: 16'hFFFF,
                             fix_chk: 1'b0, known: 1'b1,
                             want: '{src: 32'hFFFF_FFFF, dst: 32'hFFFF_FFFF, seq: 16'd1,
                                     bits: 16'd1, chk: 16'h0000, ok: 1'b0}};
        directed_rows[2] = '{src: 32'h8000_0001, dst: 32'h0001_8000, seq: 16'h8000,
                             chk: '0, size: 16'h0010, fill: 16'h8001,
                             fix_chk: 1'b1, known: 1'b0, want: '0};

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin send_gap_pct = 27; recv_stall_pct = 66; end
                1: begin send_gap_pct = 66; recv_stall_pct = 27; end
                default: begin send_gap_pct = 0; recv_stall_pct = 0; end
            endcase
            if (ph == 0)
                foreach (directed_rows[i])
                    build_packet(directed_rows[i], 1'b0);
            phase_words = 0;
            while (phase_words < PHASE_WORDS) begin
                row = random_row();
                build_packet(row, 1'b1);
                phase_words += packet_words(row.size);
            end
            while (word_q.size() != 0 || word_ch.valid)
                @(negedge i_clk);
        end

        while (expect_q.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expect_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expect_q.size()));

        $display("covered %0d packets, %0d words, %0d results checked (%0d good checksums)",
                 packets_built, words_in, results_checked, good_sums);
        $display("three stall profiles, packets of 7 to 45 words, %0d mismatches",
                 mismatches);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/phcc_pkg.sv
rtl/phcc_word_if.sv
rtl/phcc_result_if.sv
rtl/packet_header_checksum_check.sv
tb/tb_packet_header_checksum_check.sv
